/* src/modbus_rtu_response_checker_assert.svh */
// ----------------------------------------------------------------------------
// Modbus RTU response checker assertion macros
// Concurrent assertion helpers shared by the checker RTL.
// ----------------------------------------------------------------------------
`ifndef MODBUS_RTU_RESPONSE_CHECKER_ASSERT_SVH
`define MODBUS_RTU_RESPONSE_CHECKER_ASSERT_SVH

// Assertion sampled on the rising clock edge, switched off while in reset.
`define MRC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Assertion sampled on the rising clock edge, also checked during reset.
`define MRC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* src/mrc_pkg.sv */
// ----------------------------------------------------------------------------
// Modbus RTU response checker package
// Transaction types, protocol constants and the byte-wise CRC-16 update.
// ----------------------------------------------------------------------------
package mrc_pkg;

  localparam int LEN_WIDTH_DEF = 9;

  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'hA001;
  localparam logic [7:0]  FC_WRITE  = 8'h06;
  localparam logic [7:0]  FC_EXCEPT = 8'h83;
  localparam logic [7:0]  FC_READ   = 8'h03;

  typedef enum logic [2:0] {
    ST_READ      = 3'd0,
    ST_WACK      = 3'd1,
    ST_EXC       = 3'd2,
    ST_CRC       = 3'd3,
    ST_TOOSHORT  = 3'd4,
    ST_MALFORMED = 3'd5,
    ST_UNSOL     = 3'd6,
    ST_SHORT     = 3'd7
  } status_t;

  typedef struct packed {
    logic [7:0]  frame_byte;
    logic        last_byte;
    logic [15:0] pending_reg;
  } in_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] target_reg;
    logic [15:0] reg_value;
    logic [7:0]  exception_code;
    logic        advance_poll;
  } out_t;

  // Frame contents as they stand once the current byte is taken in.
  // hdr[0] is frame byte 1, hdr[4] is frame byte 5.
  typedef struct packed {
    logic [15:0]     crc;
    logic [15:0]     trail;
    logic [4:0][7:0] hdr;
  } frame_view_t;

  // One byte through the reflected CRC-16/MODBUS polynomial.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

/* src/mrc_frame.sv */
// ----------------------------------------------------------------------------
// Modbus RTU response checker frame accumulator
// Running CRC, saturating length, trailing byte pair and header capture.
// ----------------------------------------------------------------------------
module mrc_frame #(
  parameter int LEN_WIDTH = mrc_pkg::LEN_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  advance,
  input  mrc_pkg::in_t          item,
  output mrc_pkg::frame_view_t  view,
  output logic [LEN_WIDTH-1:0]  len
);
  import mrc_pkg::*;

  localparam logic [LEN_WIDTH-1:0] LenMax = {LEN_WIDTH{1'b1}};

  logic [15:0]          crc_r, crc_nxt;
  logic [LEN_WIDTH-1:0] cnt_r, cnt_nxt;
  logic [1:0][7:0]      held_r, held_nxt;
  logic [4:0][7:0]      hdr_r, hdr_nxt;

  always_comb begin
    hdr_nxt = hdr_r;
    for (int i = 0; i < 5; i++) begin
      if (cnt_r == LEN_WIDTH'(i + 1)) begin
        hdr_nxt[i] = item.frame_byte;
      end
    end
    crc_nxt  = (cnt_r >= LEN_WIDTH'(2)) ? crc_feed(crc_r, held_r[0]) : crc_r;
    held_nxt = {item.frame_byte, held_r[1]};
    cnt_nxt  = (cnt_r == LenMax) ? cnt_r : cnt_r + LEN_WIDTH'(1);
  end

  assign view.crc   = crc_nxt;
  assign view.trail = {held_nxt[1], held_nxt[0]};
  assign view.hdr   = hdr_nxt;
  assign len        = cnt_nxt;

  // The whole frame context returns to its start value after the last byte.
  always_ff @(posedge clk) begin
    if (!rst_n || (advance && item.last_byte)) begin
      crc_r  <= CRC_INIT;
      cnt_r  <= '0;
      held_r <= '0;
      hdr_r  <= '0;
    end else if (advance) begin
      crc_r  <= crc_nxt;
      cnt_r  <= cnt_nxt;
      held_r <= held_nxt;
      hdr_r  <= hdr_nxt;
    end
  end

endmodule

/* src/mrc_verdict.sv */
// ----------------------------------------------------------------------------
// Modbus RTU response checker verdict logic
// Classifies a complete frame and extracts address, value and exception code.
// ----------------------------------------------------------------------------
module mrc_verdict #(
  parameter int LEN_WIDTH = mrc_pkg::LEN_WIDTH_DEF
) (
  input  logic [LEN_WIDTH-1:0] len,
  input  mrc_pkg::frame_view_t view,
  input  logic [15:0]          pending_reg,
  output mrc_pkg::out_t        result
);
  import mrc_pkg::*;

  // Wide enough for the length and for byte count plus five.
  localparam int CW = ((LEN_WIDTH > 9) ? LEN_WIDTH : 9) + 1;

  logic [CW-1:0] len_x;
  logic [CW-1:0] need_x;
  logic [7:0]    fc;
  logic [7:0]    bc;
  status_t       st;

  assign len_x  = CW'(len);
  assign fc     = view.hdr[0];
  assign bc     = view.hdr[1];
  assign need_x = CW'(bc) + CW'(5);

  always_comb begin
    st                    = ST_SHORT;
    result.target_reg     = pending_reg;
    result.reg_value      = '0;
    result.exception_code = '0;
    priority if (len_x < CW'(5)) begin
      st = ST_TOOSHORT;
    end else if (view.crc != view.trail) begin
      st = ST_CRC;
    end else if (fc == FC_WRITE && len_x >= CW'(8)) begin
      st                = ST_WACK;
      result.target_reg = {view.hdr[1], view.hdr[2]};
      result.reg_value  = {view.hdr[3], view.hdr[4]};
    end else if (fc == FC_EXCEPT) begin
      st                    = ST_EXC;
      result.exception_code = view.hdr[1];
    end else if (pending_reg == 16'd0) begin
      st = ST_UNSOL;
    end else if (len_x >= CW'(7) && fc == FC_READ && (bc < 8'd2 || len_x < need_x)) begin
      st = ST_MALFORMED;
    end else if (len_x >= CW'(7)) begin
      st               = ST_READ;
      result.reg_value = {view.hdr[2], view.hdr[3]};
    end else begin
      st = ST_SHORT;
    end
    result.status       = st;
    result.advance_poll = (st == ST_READ) || (st == ST_EXC);
  end

endmodule

/* src/modbus_rtu_response_checker.sv */
// ----------------------------------------------------------------------------
// Modbus RTU response checker
// Byte-wise CRC-16/MODBUS check and classification of Modbus RTU responses.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Payload        | Transactions
//  --------+-----------+----------------+-----------------------------------
//  in_     | input     | mrc_pkg::in_t  | one per frame byte
//  out_    | output    | mrc_pkg::out_t | one per frame, on the last byte
//
// A byte can be accepted in every cycle unless a stalled last byte holds
// the input register. Each byte is held in the input register, where the
// frame logic and the verdict are evaluated; the verdict of a last byte is
// then written to the output register, which drives out_valid.
// Reset (rst_n low, synchronous) empties both registers and reloads the
// frame context: CRC to 0xFFFF, length, held and header bytes to zero.
// Only a last byte waits, for as long as a previous verdict is not taken;
// other bytes keep flowing while the output is stalled.
//
module modbus_rtu_response_checker #(
  parameter int LEN_WIDTH = mrc_pkg::LEN_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  mrc_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output mrc_pkg::out_t out_data
);
  import mrc_pkg::*;

  `include "modbus_rtu_response_checker_assert.svh"

  logic                 in_valid_r;
  in_t                  in_data_r;
  logic                 out_valid_r;
  out_t                 out_data_r;

  logic                 out_free;
  logic                 s1_adv;
  frame_view_t          view;
  logic [LEN_WIDTH-1:0] len;
  out_t                 verdict;

  // The output slot is free when empty or when its transaction completes now.
  assign out_free = !out_valid_r || out_ready;

  // A byte in the input register moves on unless it closes a frame and the
  // previous verdict is still waiting.
  assign s1_adv   = in_valid_r && (!in_data_r.last_byte || out_free);
  assign in_ready = !in_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_valid_r <= 1'b1;
    end else if (s1_adv) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
  end

  // Frame context: CRC, saturating length and captured bytes.
  mrc_frame #(
    .LEN_WIDTH(LEN_WIDTH)
  ) u_frame (
    .clk    (clk),
    .rst_n  (rst_n),
    .advance(s1_adv),
    .item   (in_data_r),
    .view   (view),
    .len    (len)
  );

  // Classification of the frame as it stands after the current byte.
  mrc_verdict #(
    .LEN_WIDTH(LEN_WIDTH)
  ) u_verdict (
    .len        (len),
    .view       (view),
    .pending_reg(in_data_r.pending_reg),
    .result     (verdict)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && in_data_r.last_byte) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && in_data_r.last_byte) begin
      out_data_r <= verdict;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The input stage only stalls on a last byte behind a waiting verdict.
  `MRC_ASSERT(a_stall_cause, in_valid_r && !in_ready |-> in_data_r.last_byte && out_valid_r && !out_ready, "input stage stalled without a waiting verdict")
  // A held byte is never dropped from the input register.
  `MRC_ASSERT(a_hold_byte, in_valid_r && !s1_adv |=> in_valid_r, "input byte lost while stalled")
  // The poll flag follows the verdict.
  `MRC_ASSERT(a_poll_flag, out_valid_r |-> out_data_r.advance_poll == (out_data_r.status == ST_READ || out_data_r.status == ST_EXC), "advance_poll does not match status")
  // Exception code is only reported with an exception verdict.
  `MRC_ASSERT(a_exc_code, out_valid_r && out_data_r.status != ST_EXC |-> out_data_r.exception_code == 8'd0, "exception code set on a non-exception verdict")

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Modbus RTU response checker testbench
// Feeds response frames one byte per transaction and predicts each verdict
// with an independent CRC-16 and classifier. A short table of hand-built
// frames opens the run. Random frames follow under three idle patterns, and
// one over-long frame drives the length counter into saturation.
// ----------------------------------------------------------------------------
module tb_top;
  import mrc_pkg::*;

  localparam int          LEN_W       = LEN_WIDTH_DEF;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int          PHASE_BYTES = 330;

  // Where a byte of a planned frame comes from. The CRC kinds are resolved
  // at send time from the CRC of the bytes already sent in this frame. The
  // inverted kinds make sure that the trailer cannot match.
  typedef enum logic [2:0] {
    BK_RAW,
    BK_CRC_LO,
    BK_CRC_HI,
    BK_BAD_LO,
    BK_BAD_HI
  } byte_src_t;

  typedef struct packed {
    byte_src_t   src;
    logic [7:0]  value;
    logic        last;
    logic [15:0] pend;
    logic        typed;
    out_t        want;
  } byte_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  modbus_rtu_response_checker dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #1 clk = ~clk;

  // Verdicts that the frames sent so far must still produce, oldest first.
  out_t        pending_verdicts[$];
  int unsigned fault_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_gap_pct = 0;
  int unsigned recv_gap_pct = 0;

  // CRC of the bytes sent so far in the current frame. It is used only to
  // build trailers, and kept apart from the predictor state.
  logic [15:0] wire_crc = CRC_INIT;

  // Predictor state for the frame under way.
  logic [15:0]      run_crc;
  logic [LEN_W-1:0] run_len;
  logic [7:0]       tail_q[2];
  logic [7:0]       hdr_q[5];

  byte_row_t opening_rows[26];

  // Reflected CRC-16, one data bit at a time, least significant bit first.
  function automatic logic [15:0] crc16_update(input logic [15:0] acc,
                                               input logic [7:0] octet);
    logic [15:0] r;
    logic        fb;
    r = acc;
    for (int i = 0; i < 8; i++) begin
      fb = r[0] ^ octet[i];
      r  = {1'b0, r[15:1]};
      if (fb) r = r ^ CRC_POLY;
    end
    return r;
  endfunction

  function automatic void restart_frame();
    run_crc = CRC_INIT;
    run_len = '0;
    tail_q  = '{8'h00, 8'h00};
    hdr_q   = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
  endfunction

  // Takes in one accepted byte. Returns 1 and fills the verdict when the
  // byte closes a frame.
  function automatic bit judge_byte(input in_t item, output out_t verdict);
    int unsigned pos;
    int unsigned len;
    logic [7:0]  fc;
    logic [7:0]  cnt;
    logic [15:0] trail;
    verdict = '0;
    pos = int'(run_len);
    if (pos >= 1 && pos <= 5) hdr_q[pos-1] = item.frame_byte;
    // The CRC lags two bytes behind, so the trailer never enters it.
    if (pos >= 2) run_crc = crc16_update(run_crc, tail_q[0]);
    tail_q[0] = tail_q[1];
    tail_q[1] = item.frame_byte;
    if (run_len != '1) run_len = run_len + 1'b1;
    if (!item.last_byte) return 1'b0;

    len   = int'(run_len);
    fc    = hdr_q[0];
    cnt   = hdr_q[1];
    trail = {tail_q[1], tail_q[0]};
    verdict.target_reg = item.pending_reg;
    if (len < 5) begin
      verdict.status = ST_TOOSHORT;
    end else if (run_crc != trail) begin
      verdict.status = ST_CRC;
    end else if (fc == FC_WRITE && len >= 8) begin
      verdict.status     = ST_WACK;
      verdict.target_reg = {hdr_q[1], hdr_q[2]};
      verdict.reg_value  = {hdr_q[3], hdr_q[4]};
    end else if (fc == FC_EXCEPT) begin
      verdict.status         = ST_EXC;
      verdict.exception_code = hdr_q[1];
    end else if (item.pending_reg == 16'h0000) begin
      verdict.status = ST_UNSOL;
    end else if (len >= 7 && fc == FC_READ && (cnt < 2 || len < int'(cnt) + 5)) begin
      verdict.status = ST_MALFORMED;
    end else if (len >= 7) begin
      verdict.status    = ST_READ;
      verdict.reg_value = {hdr_q[2], hdr_q[3]};
    end else begin
      verdict.status = ST_SHORT;
    end
    verdict.advance_poll = (verdict.status == ST_READ || verdict.status == ST_EXC);
    restart_frame();
    return 1'b1;
  endfunction

  // Drives one byte as an input transaction. Valid stays high between
  // back-to-back bytes and drops only for idle cycles. The verdict is
  // predicted once the byte is accepted.
  task automatic send_row(input byte_row_t row);
    in_t  item;
    out_t verdict;
    item.last_byte   = row.last;
    item.pending_reg = row.pend;
    unique case (row.src)
      BK_CRC_LO: item.frame_byte = wire_crc[7:0];
      BK_CRC_HI: item.frame_byte = wire_crc[15:8];
      BK_BAD_LO: item.frame_byte = ~wire_crc[7:0];
      BK_BAD_HI: item.frame_byte = ~wire_crc[15:8];
      default:   item.frame_byte = row.value;
    endcase
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    if (row.src == BK_RAW) wire_crc = crc16_update(wire_crc, row.value);
    if (row.last) wire_crc = CRC_INIT;
    if (judge_byte(item, verdict)) begin
      pending_verdicts.push_back(row.typed ? row.want : verdict);
    end
  endtask

  // Builds and sends one frame: slave address, function code, then the body.
  // For reads the byte count is mostly consistent with the length. Most
  // trailers carry the right CRC. The rest are corrupted in one byte or are
  // plain noise.
  task automatic send_frame(input int unsigned len, input logic [7:0] fc,
                            input logic [15:0] pend);
    byte_row_t   row;
    int unsigned tail_mode;
    int unsigned pick;
    tail_mode = $urandom_range(0, 19);
    for (int unsigned i = 0; i < len; i++) begin
      row       = '0;
      row.src   = BK_RAW;
      row.last  = (i == len - 1);
      row.pend  = row.last ? pend : 16'($urandom_range(0, 65535));
      row.value = 8'($urandom_range(0, 255));
      if (i == 1) row.value = fc;
      if (i == 2 && fc == FC_READ) begin
        pick = $urandom_range(0, 4);
        if (pick <= 2) row.value = (len < 7) ? 8'd2 : ((len - 5 > 255) ? 8'd255 : 8'(len - 5));
        else if (pick == 3) row.value = 8'($urandom_range(0, 3));
      end
      if (len >= 4 && i == len - 2) begin
        row.src = (tail_mode == 17) ? BK_BAD_LO : (tail_mode == 19) ? BK_RAW : BK_CRC_LO;
      end
      if (len >= 4 && i == len - 1) begin
        row.src = (tail_mode == 18) ? BK_BAD_HI : (tail_mode == 19) ? BK_RAW : BK_CRC_HI;
      end
      send_row(row);
    end
  endtask

  function automatic int unsigned pick_length();
    unique case ($urandom_range(0, 9))
      0:       return $urandom_range(1, 4);
      8:       return $urandom_range(11, 16);
      9:       return $urandom_range(17, 40);
      default: return $urandom_range(5, 10);
    endcase
  endfunction

  function automatic logic [7:0] pick_function_code();
    unique case ($urandom_range(0, 9))
      5, 6:    return FC_WRITE;
      7:       return FC_EXCEPT;
      8, 9:    return 8'($urandom_range(0, 255));
      default: return FC_READ;
    endcase
  endfunction

  // A zero pending register marks the response as unsolicited.
  function automatic logic [15:0] pick_pending();
    unique case ($urandom_range(0, 19))
      0, 1:    return 16'h0000;
      2:       return 16'hFFFF;
      default: return 16'($urandom_range(1, 65535));
    endcase
  endfunction

  // Holds the sender off until every verdict in flight has been taken.
  task automatic drain_verdicts();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_verdicts.size() != 0);
  endtask

  function automatic void compare_field(input string field, input logic [15:0] want,
                                        input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      fault_count++;
    end
  endfunction

  // The receiver stalls at random. The rate is set per phase.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_gap_pct);
  end

  // Every result transaction is checked against the oldest prediction.
  always @(posedge clk) begin : verdict_check
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected result, actual %h", $time, out_data);
        fault_count++;
      end else begin
        want = pending_verdicts.pop_front();
        compare_field("status", 16'(want.status), 16'(out_data.status));
        compare_field("target_reg", want.target_reg, out_data.target_reg);
        compare_field("reg_value", want.reg_value, out_data.reg_value);
        compare_field("exception_code", 16'(want.exception_code),
                      16'(out_data.exception_code));
        compare_field("advance_poll", 16'(want.advance_poll), 16'(out_data.advance_poll));
      end
    end
  end

  // Watchdog. It fires only when the DUT hangs or stops taking bytes.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    restart_frame();

    // Hand-built frames. Each verdict that is plain from the bytes is typed
    // in. The read frame at the end is left to the predictor.
    opening_rows = '{
      // A lone last byte is too short.
      '{BK_RAW,    8'h00, 1'b1, 16'h0000, 1'b1,
        '{ST_TOOSHORT, 16'h0000, 16'h0000, 8'h00, 1'b0}},
      // Exception response with a good CRC.
      '{BK_RAW,    8'h01, 1'b0, 16'hFFFF, 1'b0, '0},
      '{BK_RAW,    8'h83, 1'b0, 16'hFFFF, 1'b0, '0},
      '{BK_RAW,    8'h02, 1'b0, 16'hFFFF, 1'b0, '0},
      '{BK_CRC_LO, 8'h00, 1'b0, 16'hFFFF, 1'b0, '0},
      '{BK_CRC_HI, 8'h00, 1'b1, 16'hFFFF, 1'b1,
        '{ST_EXC, 16'hFFFF, 16'h0000, 8'h02, 1'b1}},
      // Trailer inverted, so the CRC check must fail.
      '{BK_RAW,    8'h01, 1'b0, 16'h0100, 1'b0, '0},
      '{BK_RAW,    8'h03, 1'b0, 16'h0100, 1'b0, '0},
      '{BK_RAW,    8'h02, 1'b0, 16'h0100, 1'b0, '0},
      '{BK_BAD_LO, 8'h00, 1'b0, 16'h0100, 1'b0, '0},
      '{BK_BAD_HI, 8'h00, 1'b1, 16'h0100, 1'b1,
        '{ST_CRC, 16'h0100, 16'h0000, 8'h00, 1'b0}},
      // Write acknowledge echoes its own address and value.
      '{BK_RAW,    8'h01, 1'b0, 16'h0005, 1'b0, '0},
      '{BK_RAW,    8'h06, 1'b0, 16'h0005, 1'b0, '0},
      '{BK_RAW,    8'h00, 1'b0, 16'h0005, 1'b0, '0},
      '{BK_RAW,    8'h10, 1'b0, 16'h0005, 1'b0, '0},
      '{BK_RAW,    8'hAB, 1'b0, 16'h0005, 1'b0, '0},
      '{BK_RAW,    8'hCD, 1'b0, 16'h0005, 1'b0, '0},
      '{BK_CRC_LO, 8'h00, 1'b0, 16'h0005, 1'b0, '0},
      '{BK_CRC_HI, 8'h00, 1'b1, 16'h0005, 1'b1,
        '{ST_WACK, 16'h0010, 16'hABCD, 8'h00, 1'b0}},
      // Read of an all-ones value.
      '{BK_RAW,    8'hFF, 1'b0, 16'h8001, 1'b0, '0},
      '{BK_RAW,    8'h03, 1'b0, 16'h8001, 1'b0, '0},
      '{BK_RAW,    8'h02, 1'b0, 16'h8001, 1'b0, '0},
      '{BK_RAW,    8'hFF, 1'b0, 16'h8001, 1'b0, '0},
      '{BK_RAW,    8'hFF, 1'b0, 16'h8001, 1'b0, '0},
      '{BK_CRC_LO, 8'h00, 1'b0, 16'h8001, 1'b0, '0},
      '{BK_CRC_HI, 8'h00, 1'b1, 16'h8001, 1'b0, '0}
    };

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    send_gap_pct = 31;
    recv_gap_pct <= 60;
    foreach (opening_rows[i]) send_row(opening_rows[i]);

    // Three random phases. The receiver is sparse first, then the sender,
    // then both run flat out. Each phase ends with a full drain.
    for (int phase = 0; phase < 3; phase++) begin
      int unsigned sent;
      int unsigned len;
      sent = 0;
      send_gap_pct = (phase == 0) ? 31 : (phase == 1) ? 60 : 0;
      recv_gap_pct <= (phase == 0) ? 60 : (phase == 1) ? 31 : 0;
      while (sent < PHASE_BYTES) begin
        len = pick_length();
        send_frame(len, pick_function_code(), pick_pending());
        sent += len;
      end
      // One frame longer than the length counter can hold. The length
      // saturates, and the CRC and trailer must still line up.
      if (phase == 2) send_frame($urandom_range(512, 528), FC_READ, pick_pending());
      drain_verdicts();
    end

    repeat (8) @(posedge clk);
    if (fault_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+src
src/mrc_pkg.sv
src/mrc_frame.sv
src/mrc_verdict.sv
src/modbus_rtu_response_checker.sv
verif/tb_top.sv
